@@ rtl/core/hrsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_pkg
// shared types, codes and helpers of the hex record stream parser
// ----------------------------------------------------------------------------
package hrsp_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int POS_BITS    = 10;

  localparam logic [POS_BITS-1:0] POS_MAX   = '1;
  localparam logic [7:0]          CHAR_COLON = 8'h3A;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_COLON = 3'd1;
  localparam logic [2:0] ST_BAD_HEX  = 3'd2;
  localparam logic [2:0] ST_LEN      = 3'd3;
  localparam logic [2:0] ST_SUM      = 3'd4;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // header bytes before the data field: length, address high, address low, type
  localparam logic [8:0] HDR_BYTES = 9'd4;

  typedef struct packed {
    logic                   kind;
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] buffer_offset;
    logic [7:0]             record_type;
    logic [2:0]             status;
    logic                   stopped;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [POS_BITS-1:0]    char_pos;
    logic [3:0]             high_nibble;
    logic [7:0]             rec_len;
    logic [7:0]             type_byte;
    logic [7:0]             run_sum;
    logic [2:0]             err_code;
    logic [OFFSET_BITS-1:0] data_count;
    logic                   halted;
  } parse_state_t;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ rtl/core/hex_record_stream_parser_top.sv @@
`timescale 1ns / 1ps
// a result beat is registered in the result queue before it reaches the out_ port
// throughput: one character per cycle if in_ready; line end with a data byte gives two beats
// in_ready depends only on the fill of the four-entry result queue, never on out_ready
// reset (rst_n low, synchronous) clears parser state, offset counter, halt flag and queue
// ----------------------------------------------------------------------------
// hex_record_stream_parser_top
// parses hex record lines one character per beat into data and status beats
// ----------------------------------------------------------------------------
module hex_record_stream_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // character channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_char_code,
  input  logic                            in_line_end,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_data_byte,
  output logic [hrsp_pkg::OFFSET_BITS-1:0] out_buffer_offset,
  output logic [7:0]                      out_record_type,
  output logic [2:0]                      out_status,
  output logic                            out_stopped,
  output logic                            out_last
);

  // parser state, updated once per accepted character
  hrsp_pkg::parse_state_t st_r;
  hrsp_pkg::parse_state_t st_nxt;

  logic              data_vld;
  logic              stat_vld;
  hrsp_pkg::result_t data_res;
  hrsp_pkg::result_t stat_res;

  // result queue: four entries, up to two pushed per beat
  hrsp_pkg::result_t q_mem [4];
  logic [1:0]        wr_ptr_r;
  logic [1:0]        rd_ptr_r;
  logic [2:0]        count_r;
  logic [2:0]        count_nxt;

  logic              in_acc;
  logic              out_acc;
  logic [1:0]        n_push;
  hrsp_pkg::result_t first_res;

  hrsp_decode u_decode (
    .char_code (in_char_code),
    .line_end  (in_line_end),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .data_vld  (data_vld),
    .data_res  (data_res),
    .stat_vld  (stat_vld),
    .stat_res  (stat_res)
  );

  // room for two beats is always kept before a character is taken
  assign in_ready = (count_r < 3'd3);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (count_r != 3'd0);
  assign out_acc   = out_valid && out_ready;

  // data beat goes first when a byte completes on the line's last character
  assign n_push    = in_acc ? ({1'b0, data_vld} + {1'b0, stat_vld}) : 2'd0;
  assign first_res = data_vld ? data_res : stat_res;
  assign count_nxt = count_r + {1'b0, n_push} - {2'b00, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      wr_ptr_r <= wr_ptr_r + n_push;
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_nxt;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem[wr_ptr_r] <= first_res;
    end
    if (n_push == 2'd2) begin
      q_mem[wr_ptr_r + 2'd1] <= stat_res;
    end
  end

  assign out_kind          = q_mem[rd_ptr_r].kind;
  assign out_data_byte     = q_mem[rd_ptr_r].data_byte;
  assign out_buffer_offset = q_mem[rd_ptr_r].buffer_offset;
  assign out_record_type   = q_mem[rd_ptr_r].record_type;
  assign out_status        = q_mem[rd_ptr_r].status;
  assign out_stopped       = q_mem[rd_ptr_r].stopped;
  assign out_last          = q_mem[rd_ptr_r].last;

endmodule

@@ rtl/core/hrsp_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_decode
// per-character decode: next parser state and up to two results
// ----------------------------------------------------------------------------
module hrsp_decode (
  input  logic [7:0]            char_code,
  input  logic                  line_end,
  input  hrsp_pkg::parse_state_t st,
  output hrsp_pkg::parse_state_t st_nxt,
  output logic                  data_vld,
  output hrsp_pkg::result_t     data_res,
  output logic                  stat_vld,
  output hrsp_pkg::result_t     stat_res
);

  always_comb begin
    logic [4:0]  hv;
    logic [3:0]  v;
    logic [7:0]  byte_val;
    logic [8:0]  idx;
    logic [8:0]  idx_rel;
    logic [10:0] total;
    logic [10:0] expect_len;
    logic [2:0]  stat;
    logic        stop;

    st_nxt     = st;
    data_vld   = 1'b0;
    stat_vld   = 1'b0;
    data_res   = '0;
    stat_res   = '0;
    hv         = hrsp_pkg::hex_value(char_code);
    v          = hv[3:0];
    byte_val   = '0;
    idx        = st.char_pos[hrsp_pkg::POS_BITS-1:1] - 9'd1;
    idx_rel    = idx - hrsp_pkg::HDR_BYTES;
    total      = '0;
    expect_len = '0;
    stat       = hrsp_pkg::ST_OK;
    stop       = 1'b0;

    if (!st.halted) begin
      if (st.char_pos == '0) begin
        if (char_code != hrsp_pkg::CHAR_COLON && st.err_code == hrsp_pkg::ST_OK) begin
          st_nxt.err_code = hrsp_pkg::ST_NO_COLON;
        end
      end else begin
        if (hv[4]) begin
          if (st.err_code == hrsp_pkg::ST_OK) begin
            st_nxt.err_code = hrsp_pkg::ST_BAD_HEX;
          end
          v = '0;
        end
        if (st.char_pos[0]) begin
          st_nxt.high_nibble = v;
        end else begin
          byte_val       = {st.high_nibble, v};
          st_nxt.run_sum = st.run_sum + byte_val;
          if (idx == 9'd0) begin
            st_nxt.rec_len = byte_val;
          end else if (idx == 9'd3) begin
            st_nxt.type_byte = byte_val;
          end else if (idx >= hrsp_pkg::HDR_BYTES && idx_rel < {1'b0, st.rec_len} &&
                       st_nxt.err_code == hrsp_pkg::ST_OK) begin
            data_vld               = 1'b1;
            data_res.kind          = hrsp_pkg::KIND_DATA;
            data_res.data_byte     = byte_val;
            data_res.buffer_offset = st.data_count;
            data_res.record_type   = st.type_byte;
            data_res.status        = hrsp_pkg::ST_OK;
            data_res.stopped       = 1'b0;
            data_res.last          = !line_end;
            st_nxt.data_count      = st.data_count + 1'b1;
          end
        end
      end

      if (st.char_pos != hrsp_pkg::POS_MAX) begin
        st_nxt.char_pos = st.char_pos + 1'b1;
      end

      if (line_end) begin
        // expected line length is 2 * length + 11 characters
        total      = {1'b0, st.char_pos} + 11'd1;
        expect_len = {2'b00, st_nxt.rec_len, 1'b0} + 11'd11;
        if (st_nxt.err_code != hrsp_pkg::ST_OK) begin
          stat = st_nxt.err_code;
        end else if (total != expect_len) begin
          stat = hrsp_pkg::ST_LEN;
        end else if (st_nxt.run_sum != 8'd0) begin
          stat = hrsp_pkg::ST_SUM;
        end
        stop = (stat != hrsp_pkg::ST_OK) || (st_nxt.type_byte != 8'd0);

        stat_vld               = 1'b1;
        stat_res.kind          = hrsp_pkg::KIND_STATUS;
        stat_res.data_byte     = '0;
        stat_res.buffer_offset = st_nxt.data_count;
        stat_res.record_type   = st_nxt.type_byte;
        stat_res.status        = stat;
        stat_res.stopped       = stop;
        stat_res.last          = 1'b1;

        st_nxt.halted      = stop;
        st_nxt.char_pos    = '0;
        st_nxt.high_nibble = '0;
        st_nxt.rec_len     = '0;
        st_nxt.type_byte   = '0;
        st_nxt.run_sum     = '0;
        st_nxt.err_code    = hrsp_pkg::ST_OK;
      end
    end
  end

endmodule

@@ rtl/core/hrsp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsp_checker
// port-level checks of the hex record stream parser
// ----------------------------------------------------------------------------
module hrsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_kind,
  input logic [7:0]                       out_data_byte,
  input logic [hrsp_pkg::OFFSET_BITS-1:0] out_buffer_offset,
  input logic [2:0]                       out_status,
  input logic                             out_stopped,
  input logic                             out_last
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
      $stable(out_buffer_offset) && $stable(out_kind))
    else $error("stalled result beat changed");

  // a status beat always closes the character's results
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == hrsp_pkg::KIND_STATUS |-> out_last)
    else $error("status beat without last");

  // data beats carry no status and never halt
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == hrsp_pkg::KIND_DATA |->
      out_status == hrsp_pkg::ST_OK && !out_stopped)
    else $error("data beat with status or stop");

  // any error halts the parser
  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == hrsp_pkg::KIND_STATUS && out_status != hrsp_pkg::ST_OK
      |-> out_stopped)
    else $error("error status without stop");

endmodule

bind hex_record_stream_parser_top hrsp_checker u_hrsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_data_byte     (out_data_byte),
  .out_buffer_offset (out_buffer_offset),
  .out_status        (out_status),
  .out_stopped       (out_stopped),
  .out_last          (out_last)
);

@@ tb/tb_hex_record_stream_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_record_stream_parser_top
// feeds hex record lines one character per beat into the parser; checks every
// data and status beat against the directed table or a cycle-free software
// parser kept in step with accepted characters; ends with one halting record
// ----------------------------------------------------------------------------
module tb_hex_record_stream_parser_top;
  import hrsp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_CHARS  = 390;
  localparam int BIG_LEN       = 100;
  localparam int PAUSE_AT      = 200;
  localparam int LONG_HOLD     = 60;
  localparam int NOISE_CHARS   = 24;
  localparam int MAX_REPORTS   = 10;
  localparam int DIR_ROWS      = 24;

  // ways the final record stops the parser
  typedef enum int {
    HALT_NO_COLON,
    HALT_BAD_HEX,
    HALT_EXCESS,
    HALT_TRUNCATED,
    HALT_SUM,
    HALT_TYPE
  } halt_case_t;

  typedef logic [7:0] text_t[$];

  // software copy of the parser state
  typedef struct packed {
    logic [POS_BITS-1:0]    pos;
    logic [3:0]             hi_nib;
    logic [7:0]             rec_len;
    logic [7:0]             rec_type;
    logic [7:0]             sum;
    logic [2:0]             err;
    logic [OFFSET_BITS-1:0] next_offs;
    logic                   halted;
  } parser_view_t;

  // one row of the directed table; typed rows carry their beats literally
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       typed;
    logic [1:0] n_beats;
    result_t    b0;
    result_t    b1;
  } dir_row_t;

  localparam result_t NO_BEAT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_char_code = 8'h00;
  logic                   in_line_end = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_kind;
  logic [7:0]             out_data_byte;
  logic [OFFSET_BITS-1:0] out_buffer_offset;
  logic [7:0]             out_record_type;
  logic [2:0]             out_status;
  logic                   out_stopped;
  logic                   out_last;

  parser_view_t view;
  result_t      pending_beats[$];
  dir_row_t     dir_rows [DIR_ROWS];
  halt_case_t   halt_pick;

  int  error_count = 0;
  int  chars_sent = 0;
  int  lines_sent = 0;
  int  beats_checked = 0;
  int  cycle_count = 0;
  int  drain_beats = 0;
  bit  drain_held = 1'b0;
  bit  steady_tail = 1'b0;

  hex_record_stream_parser_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_line_end       (in_line_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_buffer_offset (out_buffer_offset),
    .out_record_type   (out_record_type),
    .out_status        (out_status),
    .out_stopped       (out_stopped),
    .out_last          (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // beat builders and the software parser
  // ---------------------------------------------------------------------------

  function automatic result_t data_beat(logic [7:0] b, logic [OFFSET_BITS-1:0] offs,
                                        logic [7:0] typ, logic lst);
    result_t r;
    r = '0;
    r.kind          = KIND_DATA;
    r.data_byte     = b;
    r.buffer_offset = offs;
    r.record_type   = typ;
    r.status        = ST_OK;
    r.last          = lst;
    return r;
  endfunction

  function automatic result_t status_beat(logic [OFFSET_BITS-1:0] offs, logic [7:0] typ,
                                          logic [2:0] st, logic stop);
    result_t r;
    r = '0;
    r.kind          = KIND_STATUS;
    r.buffer_offset = offs;
    r.record_type   = typ;
    r.status        = st;
    r.stopped       = stop;
    r.last          = 1'b1;
    return r;
  endfunction

  // 0..15 for a hex digit, 16 for anything else
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      return {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      return {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return 5'h10;
  endfunction

  // letters come out in random case
  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + 8'(d);
    end
    return ($urandom_range(0, 1) ? 8'h57 : 8'h37) + 8'(d);
  endfunction

  // advance the software parser by one character, giving up to two beats
  task automatic parse_char(input logic [7:0] c, input logic eol, output int n,
                            output result_t b0, output result_t b1);
    logic [POS_BITS-1:0] pos;
    logic [4:0]          v;
    logic [7:0]          b;
    logic [2:0]          st;
    logic                stop;
    result_t             beat;
    int                  idx;
    int                  want;
    n  = 0;
    b0 = NO_BEAT;
    b1 = NO_BEAT;
    if (view.halted) begin
      return;
    end
    pos = view.pos;
    if (pos == '0) begin
      if (c != CHAR_COLON && view.err == ST_OK) begin
        view.err = ST_NO_COLON;
      end
    end else begin
      v = nibble_of(c);
      if (v > 5'd15) begin
        if (view.err == ST_OK) begin
          view.err = ST_BAD_HEX;
        end
        v = '0;
      end
      if (pos[0]) begin
        view.hi_nib = v[3:0];
      end else begin
        b   = {view.hi_nib, v[3:0]};
        idx = int'(pos) / 2 - 1;
        view.sum = view.sum + b;
        if (idx == 0) begin
          view.rec_len = b;
        end else if (idx == 3) begin
          view.rec_type = b;
        end else if (idx >= 4 && idx < 4 + int'(view.rec_len) && view.err == ST_OK) begin
          // a byte finishing on the line end is followed by the status beat
          b0 = data_beat(b, view.next_offs, view.rec_type, !eol);
          n  = 1;
          view.next_offs = view.next_offs + 1'b1;
        end
      end
    end
    if (pos != POS_MAX) begin
      view.pos = pos + 1'b1;
    end
    if (eol) begin
      want = (5 + int'(view.rec_len)) * 2 + 1;
      if (view.err != ST_OK) begin
        st = view.err;
      end else if (int'(pos) + 1 != want) begin
        st = ST_LEN;
      end else if (view.sum != 8'h00) begin
        st = ST_SUM;
      end else begin
        st = ST_OK;
      end
      stop = (st != ST_OK) || (view.rec_type != 8'h00);
      beat = status_beat(view.next_offs, view.rec_type, st, stop);
      if (n == 0) begin
        b0 = beat;
      end else begin
        b1 = beat;
      end
      n++;
      view.halted   = view.halted | stop;
      view.pos      = '0;
      view.hi_nib   = '0;
      view.rec_len  = '0;
      view.rec_type = '0;
      view.sum      = '0;
      view.err      = ST_OK;
    end
  endtask

  // ---------------------------------------------------------------------------
  // record text generation
  // ---------------------------------------------------------------------------

  // colon, length, random address, type, random data, checksum plus skew
  function automatic text_t make_record(int unsigned len, logic [7:0] typ,
                                        logic [7:0] sum_skew);
    text_t      t;
    logic [7:0] body[$];
    logic [7:0] acc;
    body = {8'(len), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), typ};
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
    acc = 8'h00;
    foreach (body[i]) acc = acc + body[i];
    body.push_back(8'h00 - acc + sum_skew);
    t.push_back(CHAR_COLON);
    foreach (body[i]) begin
      t.push_back(hex_char(body[i][7:4]));
      t.push_back(hex_char(body[i][3:0]));
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // character side
  // ---------------------------------------------------------------------------

  // offer one beat, hold it until taken, then run the software parser on it
  task automatic offer_char(input logic [7:0] ch, input logic eol, input bit keep);
    int      n;
    result_t b0;
    result_t b1;
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    in_line_end  <= eol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    parse_char(ch, eol, n, b0, b1);
    if (keep && n > 0) begin
      pending_beats.push_back(b0);
    end
    if (keep && n > 1) begin
      pending_beats.push_back(b1);
    end
  endtask

  task automatic send_line(input text_t t);
    foreach (t[i]) offer_char(t[i], i == t.size() - 1, 1'b1);
    lines_sent++;
  endtask

  // stop offering and let every outstanding beat come back
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold that fills the queue
  // ---------------------------------------------------------------------------

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        drain_beats++;
      end
      if (!drain_held && drain_beats >= 40) begin
        // the sender keeps offering here, so in_ready has to drop
        drain_held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, what);
      $display("  expected kind %0d byte %h offs %h type %h status %0d stop %0d last %0d",
               want.kind, want.data_byte, want.buffer_offset, want.record_type,
               want.status, want.stopped, want.last);
      $display("  actual   kind %0d byte %h offs %h type %h status %0d stop %0d last %0d",
               got.kind, got.data_byte, got.buffer_offset, got.record_type,
               got.status, got.stopped, got.last);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_kind, out_data_byte, out_buffer_offset, out_record_type,
             out_status, out_stopped, out_last};
      beats_checked++;
      if (pending_beats.size() == 0) begin
        note_mismatch("beat with nothing expected", NO_BEAT, got);
      end else begin
        want = pending_beats.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte
            || got.buffer_offset !== want.buffer_offset
            || got.record_type !== want.record_type || got.status !== want.status
            || got.stopped !== want.stopped || got.last !== want.last) begin
          note_mismatch("field differs", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, pending_beats.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    text_t       rec_text;
    int unsigned len;
    int unsigned k;
    int          total;
    logic [7:0]  c;
    bit          big_done;
    bit          paused;

    view = '0;
    big_done = 1'b0;
    paused = 1'b0;

    // directed table: an all-ones data byte in mixed case, then an empty record
    dir_rows = '{
      '{":", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"1", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"F", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"f", 1'b0, 1'b1, 2'd1, data_beat(8'hFF, '0, 8'h00, 1'b1), NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b1, 1'b1, 2'd1, status_beat(24'd1, 8'h00, ST_OK, 1'b0), NO_BEAT},
      '{":", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b0, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
      '{"0", 1'b1, 1'b1, 2'd1, status_beat(24'd1, 8'h00, ST_OK, 1'b0), NO_BEAT}
    };

    // synchronous reset, once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_char(dir_rows[i].ch, dir_rows[i].eol, !dir_rows[i].typed);
      if (dir_rows[i].typed) begin
        pending_beats.push_back(dir_rows[i].b0);
        if (dir_rows[i].n_beats == 2'd2) begin
          pending_beats.push_back(dir_rows[i].b1);
        end
      end
    end
    lines_sent += 2;

    // sender waits for the parser to empty out completely once
    drain_all();
    @(posedge clk);

    // well-formed type 0 records with random content; any bad record would
    // halt the parser for the rest of the run, so those come only at the end
    total = 0;
    while (total < RANDOM_CHARS) begin
      if (!big_done && total > 60) begin
        len = BIG_LEN;
        big_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 12);
      end
      rec_text = make_record(len, 8'h00, 8'h00);
      send_line(rec_text);
      total += rec_text.size();
      if (!paused && total > PAUSE_AT) begin
        paused = 1'b1;
        drain_all();
        @(posedge clk);
      end
      if (total > RANDOM_CHARS - 100) begin
        steady_tail = 1'b1;
      end
    end
    steady_tail = 1'b1;

    // one closing record that stops the parser
    halt_pick = halt_case_t'($urandom_range(0, 5));
    case (halt_pick)
      HALT_NO_COLON: begin
        rec_text = make_record($urandom_range(0, 4), 8'h00, 8'h00);
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
        rec_text[0] = c;
      end
      HALT_BAD_HEX: begin
        // data after the bad digit is suppressed; extra digits test precedence
        rec_text = make_record($urandom_range(2, 6), 8'h00, 8'h00);
        k = $urandom_range(1, rec_text.size() - 1);
        do c = 8'($urandom_range(0, 255)); while (nibble_of(c) < 5'd16);
        rec_text[k] = c;
        if ($urandom_range(0, 1)) begin
          rec_text.push_back(hex_char(4'($urandom_range(0, 15))));
        end
      end
      HALT_EXCESS: begin
        rec_text = make_record($urandom_range(0, 6), 8'h00, 8'h00);
        repeat ($urandom_range(1, 6)) rec_text.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      HALT_TRUNCATED: begin
        // line ends right on the second digit of a data byte
        len = $urandom_range(2, 6);
        rec_text = make_record(len, 8'h00, 8'h00);
        k = $urandom_range(1, len);
        while (rec_text.size() > 9 + 2 * k) void'(rec_text.pop_back());
      end
      HALT_SUM: begin
        rec_text = make_record($urandom_range(0, 6), 8'h00, 8'($urandom_range(1, 255)));
      end
      default: begin
        // nonzero record type
        rec_text = make_record($urandom_range(0, 6), 8'($urandom_range(1, 255)), 8'h00);
      end
    endcase
    send_line(rec_text);

    // halted: anything at all is taken and must give no beat
    for (int i = 0; i < NOISE_CHARS; i++) begin
      if (i == 0) begin
        c = 8'hFF;
      end else if (i == 1) begin
        c = 8'h00;
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      offer_char(c, 1'($urandom_range(0, 1)), 1'b1);
    end

    drain_all();
    repeat (10) @(posedge clk);

    $display("ran %0d characters over %0d record lines, %0d result beats checked",
             chars_sent, lines_sent, beats_checked);
    $display("closing record case %s, followed by %0d characters while halted",
             halt_pick.name(), NOISE_CHARS);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
